/* src/bma_pkg.sv */
// Shared types, constants and layout functions of the buddy allocator.
// No dependencies; imported by bma_ctrl, bma_dp and buddy_memory_allocator.
package bma_pkg;

  localparam int POOL_ORDER_DEF = 10;
  localparam int OWNER_BITS_DEF = 16;

  localparam int REQ_W   = 11;
  localparam int ADDR_W  = 10;
  localparam int UNITS_W = 11;
  localparam int MERGE_W = 4;
  localparam int WORD_W  = 32;
  localparam int WORD_LW = 5;
  localparam int ORD_FW  = 5;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_BADSIZE = 2'd2,
    ST_BADFREE = 2'd3
  } stat_e;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_CLEAR     = 4'd1,
    OP_LATCH     = 4'd2,
    OP_DECODE    = 4'd3,
    OP_SCAN_RD   = 4'd4,
    OP_SCAN_CHK  = 4'd5,
    OP_SPLIT     = 4'd6,
    OP_BUDDY_RD  = 4'd7,
    OP_BUDDY_SET = 4'd8,
    OP_FREE_CHK  = 4'd9,
    OP_MERGE     = 4'd10,
    OP_SELF_RD   = 4'd11,
    OP_SELF_SET  = 4'd12,
    OP_EMIT      = 4'd13
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic dec_err;
    logic hit;
    logic last;
    logic top;
    logic split_done;
    logic free_ok;
    logic buddy_free;
    logic out_busy;
  } sts_t;

  // rows of the free bitmap that hold the nodes of order j
  function automatic int rows_of(int p, int j);
    rows_of = (p - j > WORD_LW) ? (1 << (p - j - WORD_LW)) : 1;
  endfunction

  // first row of order k in the free bitmap
  function automatic int row_base(int p, int k);
    int s;
    s = 0;
    for (int j = 0; j < k; j++) s += rows_of(p, j);
    return s;
  endfunction

endpackage

/* src/buddy_memory_allocator.sv */
// Binary buddy allocator top level. An allocate scans the 32-bit bitmap rows until a free
// block is found, then splits it, reading and setting the buddy bit per split. A free
// checks the owner, then reads and checks the buddy per coalescing step and ends with a
// read and write of the final free mark; the free-bitmap port sets the pace. A stalled
// result holds the next load. A new transaction is taken the cycle after the result is
// loaded. After reset a clearing pass over both tables runs before the first accept.
module buddy_memory_allocator import bma_pkg::*; #(
  parameter int POOL_ORDER = POOL_ORDER_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [15:0]        owner_id_i,
  input  logic [REQ_W-1:0]   request_units_i,
  input  logic [ADDR_W-1:0]  block_address_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [ADDR_W-1:0]  start_address_o,
  output logic [UNITS_W-1:0] block_units_o,
  output logic [MERGE_W-1:0] merge_count_o
);

  cmd_t cmd;
  sts_t sts;

  bma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bma_dp #(
    .POOL_ORDER (POOL_ORDER),
    .OWNER_BITS (OWNER_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .owner_id_i      (owner_id_i),
    .request_units_i (request_units_i),
    .block_address_i (block_address_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .start_address_o (start_address_o),
    .block_units_o   (block_units_o),
    .merge_count_o   (merge_count_o)
  );

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      (start_address_o == '0) && (block_units_o == '0) && (merge_count_o == '0))
    else $error("error result carries nonzero payload");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a transaction is in flight");

  a_units_pow2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones(block_units_o) <= 1)
    else $error("block size is not a power of two");

endmodule

/* src/bma_ctrl.sv */
// Sequencer of the buddy allocator: one-hot state machine issuing datapath ops.
// Depends on bma_pkg for cmd_t, sts_t and op codes.
module bma_ctrl import bma_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [13:0] {
    S_CLEAR     = 14'b00000000000001,
    S_IDLE      = 14'b00000000000010,
    S_DECODE    = 14'b00000000000100,
    S_SCAN_RD   = 14'b00000000001000,
    S_SCAN_CHK  = 14'b00000000010000,
    S_SPLIT     = 14'b00000000100000,
    S_SPLIT_RD  = 14'b00000001000000,
    S_SPLIT_WR  = 14'b00000010000000,
    S_FREE_CHK  = 14'b00000100000000,
    S_MERGE_RD  = 14'b00001000000000,
    S_MERGE_CHK = 14'b00010000000000,
    S_SET_RD    = 14'b00100000000000,
    S_SET_WR    = 14'b01000000000000,
    S_DONE      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.op = OP_DECODE;
        if (sts_i.dec_err) state_d = S_DONE;
        else if (sts_i.is_free) state_d = S_FREE_CHK;
        else state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.op = OP_SCAN_RD;
        state_d  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd_o.op = OP_SCAN_CHK;
        if (sts_i.hit) state_d = S_SPLIT;
        else if (!sts_i.last || !sts_i.top) state_d = S_SCAN_RD;
        else state_d = S_DONE;
      end
      S_SPLIT: begin
        cmd_o.op = OP_SPLIT;
        state_d  = sts_i.split_done ? S_DONE : S_SPLIT_RD;
      end
      S_SPLIT_RD: begin
        cmd_o.op = OP_BUDDY_RD;
        state_d  = S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        cmd_o.op = OP_BUDDY_SET;
        state_d  = S_SPLIT;
      end
      S_FREE_CHK: begin
        cmd_o.op = OP_FREE_CHK;
        state_d  = sts_i.free_ok ? S_MERGE_RD : S_DONE;
      end
      S_MERGE_RD: begin
        if (sts_i.top) begin
          state_d = S_SET_RD;
        end else begin
          cmd_o.op = OP_BUDDY_RD;
          state_d  = S_MERGE_CHK;
        end
      end
      S_MERGE_CHK: begin
        cmd_o.op = OP_MERGE;
        state_d  = sts_i.buddy_free ? S_MERGE_RD : S_SET_RD;
      end
      S_SET_RD: begin
        cmd_o.op = OP_SELF_RD;
        state_d  = S_SET_WR;
      end
      S_SET_WR: begin
        cmd_o.op = OP_SELF_SET;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* src/bma_dp.sv */
// Datapath of the buddy allocator: free bitmap, allocation table, work registers.
// Depends on bma_pkg for types, layout functions and constants.
module bma_dp import bma_pkg::*; #(
  parameter int POOL_ORDER = POOL_ORDER_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               func_i,
  input  logic [15:0]        owner_id_i,
  input  logic [REQ_W-1:0]   request_units_i,
  input  logic [ADDR_W-1:0]  block_address_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [ADDR_W-1:0]  start_address_o,
  output logic [UNITS_W-1:0] block_units_o,
  output logic [MERGE_W-1:0] merge_count_o
);

  localparam int P   = POOL_ORDER;
  localparam int OB  = OWNER_BITS;
  localparam int NU  = 2 ** P;
  localparam int OW  = $clog2(P + 2);
  localparam int R   = row_base(P, P + 1);
  localparam int RW  = $clog2(R);
  localparam int CLR = (R > NU) ? R : NU;
  localparam int CW  = $clog2(CLR);
  localparam int AMW = ORD_FW + OB;

  logic [WORD_W-1:0] free_mem [R];
  logic [AMW-1:0]    alloc_mem [NU];

  logic [RW-1:0] base_w [P+2];
  logic [RW-1:0] last_w [P+1];

  for (genvar g = 0; g < P + 2; g++) begin : g_base
    assign base_w[g] = RW'(row_base(P, g));
  end
  for (genvar g = 0; g < P + 1; g++) begin : g_last
    assign last_w[g] = RW'(row_base(P, g) + rows_of(P, g) - 1);
  end

  logic [CW-1:0]      clr_q;
  logic               func_q;
  logic [OB-1:0]      own_q;
  logic [REQ_W-1:0]   req_q;
  logic [ADDR_W-1:0]  blk_q;
  logic [OW-1:0]      ord_q, tgt_q;
  logic [P-1:0]       cur_q, orig_q;
  logic [RW-1:0]      row_q;
  logic [MERGE_W-1:0] mrg_q;
  stat_e              err_q;
  logic               ov_q;
  logic [1:0]         st_q;
  logic [ADDR_W-1:0]  sa_q;
  logic [UNITS_W-1:0] bu_q;
  logic [MERGE_W-1:0] mc_q;
  logic [WORD_W-1:0]  fm_rd_q;
  logic [AMW-1:0]     am_rd_q;

  logic [REQ_W-1:0]   rm1;
  logic [OW-1:0]      kreq, ord_inc;
  logic               size_bad, addr_bad, hit, last, top, free_ok, buddy_free, flip;
  logic [WORD_LW-1:0] lowbit, nbit;
  logic [RW-1:0]      off, nrow;
  logic [31:0]        fa, nidx;
  logic [WORD_W-1:0]  nmask;
  logic [ORD_FW-1:0]  am_ord;
  logic [OB-1:0]      am_tag;
  logic               ok;

  always_comb begin
    rm1  = req_q - REQ_W'(1);
    kreq = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (rm1[i]) kreq = OW'(i + 1);
    end
  end

  assign size_bad = (req_q == '0) || (32'(req_q) > 32'(NU));
  assign addr_bad = (32'(blk_q) >= 32'(NU));
  assign ord_inc  = ord_q + OW'(1);
  assign top      = (ord_q == OW'(P));
  assign last     = (row_q == last_w[ord_q]);

  always_comb begin
    lowbit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (fm_rd_q[i]) lowbit = WORD_LW'(i);
    end
  end

  assign hit  = |fm_rd_q;
  assign off  = row_q - base_w[ord_q];
  assign fa   = ((32'(off) << WORD_LW) | 32'(lowbit)) << ord_q;

  assign flip  = (cmd_i.op == OP_BUDDY_RD) || (cmd_i.op == OP_BUDDY_SET) ||
                 (cmd_i.op == OP_MERGE);
  assign nidx  = (32'(cur_q) >> ord_q) ^ 32'(flip);
  assign nrow  = base_w[ord_q] + RW'(nidx >> WORD_LW);
  assign nbit  = nidx[WORD_LW-1:0];
  assign nmask = WORD_W'(1) << nbit;
  assign buddy_free = |(fm_rd_q & nmask);

  assign am_ord  = am_rd_q[AMW-1 -: ORD_FW];
  assign am_tag  = am_rd_q[OB-1:0];
  assign free_ok = (am_ord != '0) && (32'(am_ord) <= 32'(P + 1)) && (am_tag == own_q);

  assign sts_o.clr_done   = (32'(clr_q) == 32'(CLR - 1));
  assign sts_o.is_free    = (func_q == FN_FREE);
  assign sts_o.dec_err    = (func_q == FN_FREE) ? addr_bad : size_bad;
  assign sts_o.hit        = hit;
  assign sts_o.last       = last;
  assign sts_o.top        = top;
  assign sts_o.split_done = (ord_q == tgt_q);
  assign sts_o.free_ok    = free_ok;
  assign sts_o.buddy_free = buddy_free;
  assign sts_o.out_busy   = ov_q && out_stall_i;

  logic              fm_we, fm_re, am_we, am_re;
  logic [RW-1:0]     fm_wa, fm_ra;
  logic [WORD_W-1:0] fm_wd;
  logic [P-1:0]      am_wa;
  logic [AMW-1:0]    am_wd;

  always_comb begin
    fm_we = 1'b0;
    fm_wa = nrow;
    fm_wd = fm_rd_q;
    fm_re = 1'b0;
    fm_ra = nrow;
    am_we = 1'b0;
    am_wa = cur_q;
    am_wd = {ORD_FW'(0), am_tag};
    am_re = 1'b0;
    case (cmd_i.op)
      OP_CLEAR: begin
        fm_we = (32'(clr_q) < 32'(R));
        fm_wa = clr_q[RW-1:0];
        fm_wd = (32'(clr_q) == 32'(R - 1)) ? WORD_W'(1) : '0;
        am_we = (32'(clr_q) < 32'(NU));
        am_wa = clr_q[P-1:0];
        am_wd = '0;
      end
      OP_DECODE: am_re = (func_q == FN_FREE) && !addr_bad;
      OP_SCAN_RD: begin
        fm_re = 1'b1;
        fm_ra = row_q;
      end
      OP_SCAN_CHK: begin
        fm_we = hit;
        fm_wa = row_q;
        fm_wd = fm_rd_q & ~(WORD_W'(1) << lowbit);
      end
      OP_BUDDY_RD, OP_SELF_RD: fm_re = 1'b1;
      OP_BUDDY_SET, OP_SELF_SET: begin
        fm_we = 1'b1;
        fm_wd = fm_rd_q | nmask;
      end
      OP_MERGE: begin
        fm_we = buddy_free;
        fm_wd = fm_rd_q & ~nmask;
      end
      OP_SPLIT: begin
        am_we = (ord_q == tgt_q);
        am_wd = {ORD_FW'(tgt_q + OW'(1)), own_q};
      end
      OP_FREE_CHK: am_we = free_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fm_we) free_mem[fm_wa] <= fm_wd;
    if (fm_re) fm_rd_q <= free_mem[fm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (am_we) alloc_mem[am_wa] <= am_wd;
    if (am_re) am_rd_q <= alloc_mem[cur_q];
  end

  assign ok = (err_q == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      func_q <= FN_ALLOC;
      own_q  <= '0;
      req_q  <= '0;
      blk_q  <= '0;
      ord_q  <= '0;
      tgt_q  <= '0;
      cur_q  <= '0;
      orig_q <= '0;
      row_q  <= '0;
      mrg_q  <= '0;
      err_q  <= ST_OK;
      ov_q   <= 1'b0;
      st_q   <= '0;
      sa_q   <= '0;
      bu_q   <= '0;
      mc_q   <= '0;
    end else begin
      if (cmd_i.op == OP_EMIT) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (cmd_i.op)
        OP_CLEAR: if (!sts_o.clr_done) clr_q <= clr_q + CW'(1);
        OP_LATCH: begin
          func_q <= func_i;
          own_q  <= OB'(owner_id_i);
          req_q  <= request_units_i;
          blk_q  <= block_address_i;
          cur_q  <= P'(block_address_i);
          orig_q <= P'(block_address_i);
          mrg_q  <= '0;
          tgt_q  <= '0;
        end
        OP_DECODE: begin
          if (func_q == FN_FREE) begin
            if (addr_bad) err_q <= ST_BADFREE;
          end else if (size_bad) begin
            err_q <= ST_BADSIZE;
          end else begin
            ord_q <= kreq;
            tgt_q <= kreq;
            row_q <= base_w[kreq];
          end
        end
        OP_SCAN_CHK: begin
          if (hit) begin
            cur_q  <= fa[P-1:0];
            orig_q <= fa[P-1:0];
          end else if (!last) begin
            row_q <= row_q + RW'(1);
          end else if (!top) begin
            ord_q <= ord_inc;
            row_q <= base_w[ord_inc];
          end else begin
            err_q <= ST_NOFREE;
          end
        end
        OP_SPLIT: begin
          if (ord_q == tgt_q) err_q <= ST_OK;
          else ord_q <= ord_q - OW'(1);
        end
        OP_FREE_CHK: begin
          if (free_ok) begin
            ord_q <= OW'(am_ord - ORD_FW'(1));
            tgt_q <= OW'(am_ord - ORD_FW'(1));
          end else begin
            err_q <= ST_BADFREE;
          end
        end
        OP_MERGE: begin
          if (buddy_free) begin
            cur_q <= cur_q & ~(P'(1) << ord_q);
            ord_q <= ord_inc;
            mrg_q <= mrg_q + MERGE_W'(1);
          end
        end
        OP_SELF_SET: err_q <= ST_OK;
        OP_EMIT: begin
          st_q <= err_q;
          sa_q <= ok ? ADDR_W'(32'(orig_q)) : '0;
          bu_q <= ok ? UNITS_W'(32'(1) << tgt_q) : '0;
          mc_q <= ok ? mrg_q : '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o     = ov_q;
  assign status_o        = st_q;
  assign start_address_o = sa_q;
  assign block_units_o   = bu_q;
  assign merge_count_o   = mc_q;

endmodule

/* tb/sv/bma_checker.sv */
// Checker for the buddy allocator: watches both channels, predicts each result
// from its own copy of the free tree, owner tags and block orders, and compares.
// Depends on bma_pkg for field widths and status codes.
`timescale 1ns / 100ps
module bma_checker import bma_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               func_i,
  input  logic [15:0]        owner_id_i,
  input  logic [REQ_W-1:0]   request_units_i,
  input  logic [ADDR_W-1:0]  block_address_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic [ADDR_W-1:0]  start_address_i,
  input  logic [UNITS_W-1:0] block_units_i,
  input  logic [MERGE_W-1:0] merge_count_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int PO = POOL_ORDER_DEF;
  localparam int POOL = 1 << PO;
  localparam int NODES = (2 << PO) - 1;

  typedef struct packed {
    stat_e              status;
    logic [ADDR_W-1:0]  start;
    logic [UNITS_W-1:0] units;
    logic [MERGE_W-1:0] merges;
  } alloc_result_t;

  bit            node_free [NODES];
  logic [4:0]    live_order [POOL];
  logic [15:0]   owner_of [POOL];
  alloc_result_t awaited_results [$];

  assign pending_o = awaited_results.size();

  function automatic int node_index(int k, int a);
    return ((1 << (PO - k)) - 1) + (a >> k);
  endfunction

  function automatic alloc_result_t predict_alloc(logic [15:0] owner, int req);
    alloc_result_t r;
    int k, j, a, n;
    r = '{ST_OK, '0, '0, '0};
    if (req == 0 || req > POOL) begin
      r.status = ST_BADSIZE;
      return r;
    end
    k = 0;
    while ((1 << k) < req) k++;
    a = -1;
    for (j = k; j <= PO && a < 0; j++) begin
      n = 1 << (PO - j);
      for (int i = 0; i < n && a < 0; i++)
        if (node_free[n - 1 + i]) a = i << j;
      if (a >= 0) break;
    end
    if (a < 0) begin
      r.status = ST_NOFREE;
      return r;
    end
    node_free[node_index(j, a)] = 0;
    while (j > k) begin
      j--;
      node_free[node_index(j, a + (1 << j))] = 1;
    end
    live_order[a] = 5'(k + 1);
    owner_of[a] = owner;
    r.start = ADDR_W'(a);
    r.units = UNITS_W'(1 << k);
    return r;
  endfunction

  function automatic alloc_result_t predict_free(logic [15:0] owner, int addr);
    alloc_result_t r;
    int k, k0, cur, m, bn;
    r = '{ST_OK, '0, '0, '0};
    if (live_order[addr] == 0 || live_order[addr] > PO + 1 || owner_of[addr] != owner) begin
      r.status = ST_BADFREE;
      return r;
    end
    k = live_order[addr] - 1;
    k0 = k;
    live_order[addr] = 0;
    cur = addr;
    m = 0;
    while (k < PO) begin
      bn = node_index(k, cur ^ (1 << k));
      if (!node_free[bn]) break;
      node_free[bn] = 0;
      cur &= ~(1 << k);
      k++;
      m++;
    end
    node_free[node_index(k, cur)] = 1;
    r.start = ADDR_W'(addr);
    r.units = UNITS_W'(1 << k0);
    r.merges = MERGE_W'(m);
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    foreach (node_free[i]) node_free[i] = 0;
    foreach (live_order[i]) live_order[i] = 0;
    foreach (owner_of[i]) owner_of[i] = 0;
    node_free[0] = 1;
  end

  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        if (func_i == FN_ALLOC)
          awaited_results.push_back(predict_alloc(owner_id_i, request_units_i));
        else
          awaited_results.push_back(predict_free(owner_id_i, block_address_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t unexpected transaction on result channel", $realtime);
          fail_count_o++;
        end else begin
          e = awaited_results[0];
          awaited_results.delete(0);
          if (status_i != e.status) report("status", status_i, e.status);
          if (start_address_i != e.start) report("start_address", start_address_i, e.start);
          if (block_units_i != e.units) report("block_units", block_units_i, e.units);
          if (merge_count_i != e.merges) report("merge_count", merge_count_i, e.merges);
        end
      end
    end
  end

endmodule

/* tb/sv/tb_buddy_memory_allocator.sv */
// Top of the buddy allocator testbench: clock, reset, directed and random
// allocate/free traffic with bursty sender and stalling receiver.
// Depends on bma_pkg, buddy_memory_allocator and bma_checker.
`timescale 1ns / 100ps
module tb_buddy_memory_allocator;
  import bma_pkg::*;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               func = FN_ALLOC;
  logic [15:0]        owner_id = '0;
  logic [REQ_W-1:0]   request_units = '0;
  logic [ADDR_W-1:0]  block_address = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [1:0]         status;
  logic [ADDR_W-1:0]  start_address;
  logic [UNITS_W-1:0] block_units;
  logic [MERGE_W-1:0] merge_count;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  int                 stall_mode = 0;

  typedef struct {
    logic [9:0]  addr;
    logic [15:0] owner;
  } live_block_t;
  live_block_t live_blocks [$];

  buddy_memory_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .owner_id_i(owner_id),
    .request_units_i(request_units), .block_address_i(block_address),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .start_address_o(start_address),
    .block_units_o(block_units), .merge_count_o(merge_count)
  );

  bma_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .func_i(func), .owner_id_i(owner_id),
    .request_units_i(request_units), .block_address_i(block_address),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .start_address_i(start_address),
    .block_units_i(block_units), .merge_count_i(merge_count),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("tb_buddy_memory_allocator: errors");
      $finish;
    end
  end

  // receiver stall pattern: phases of none, light, heavy
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  task automatic send(logic f, logic [15:0] own, logic [REQ_W-1:0] req,
                      logic [ADDR_W-1:0] addr);
    func <= f;
    owner_id <= own;
    request_units <= req;
    block_address <= addr;
    in_valid <= 1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  // hold until every expected result has come
  task automatic drain();
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // track live blocks from result channel for well-formed frees
  logic last_func_q [$];
  logic [15:0] last_owner_q [$];
  always @(posedge clk_i) begin
    live_block_t b;
    if (rst_ni && in_valid && !in_stall) begin
      last_func_q.push_back(func);
      last_owner_q.push_back(owner_id);
    end
    if (rst_ni && out_valid && !out_stall && last_func_q.size() > 0) begin
      if (last_func_q[0] == FN_ALLOC && status == ST_OK) begin
        b.addr = start_address;
        b.owner = last_owner_q[0];
        live_blocks.push_back(b);
      end
      last_func_q.delete(0);
      last_owner_q.delete(0);
    end
  end

  function automatic logic [REQ_W-1:0] rand_size();
    int s;
    s = $urandom_range(0, 9);
    if (s < 6) return REQ_W'($urandom_range(1, 16));
    if (s < 9) return REQ_W'($urandom_range(1, 128));
    return REQ_W'($urandom_range(1, 1024));
  endfunction

  initial begin
    int idx, burst, r;
    live_block_t b;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send(FN_ALLOC, 16'h0000, 11'd0, 10'd0);
    send(FN_ALLOC, 16'hFFFF, 11'd1025, 10'h3FF);
    send(FN_ALLOC, 16'hFFFF, 11'h7FF, 10'd0);
    send(FN_ALLOC, 16'h1234, 11'd1024, 10'd0);
    send(FN_ALLOC, 16'h0001, 11'd1, 10'd0);
    send(FN_FREE, 16'h1235, 11'd0, 10'd0);
    send(FN_FREE, 16'h1234, 11'h7FF, 10'd0);
    send(FN_FREE, 16'h1234, 11'd0, 10'd0);
    send(FN_FREE, 16'hFFFF, 11'd0, 10'h3FF);
    send(FN_ALLOC, 16'hFFFF, 11'd1, 10'h3FF);
    send(FN_ALLOC, 16'hAAAA, 11'd3, 10'd0);
    send(FN_ALLOC, 16'h5555, 11'd1, 10'd0);
    send(FN_ALLOC, 16'h0F0F, 11'd512, 10'd0);
    send(FN_ALLOC, 16'h0F0F, 11'd513, 10'd0);
    send(FN_FREE, 16'h5555, 11'd0, 10'd1);
    send(FN_FREE, 16'hFFFF, 11'd0, 10'd0);
    send(FN_FREE, 16'hAAAA, 11'd0, 10'd4);
    send(FN_FREE, 16'h0F0F, 11'd0, 10'd512);
    send(FN_FREE, 16'h0F0F, 11'd0, 10'd512);
    drain();
    live_blocks.delete();

    for (int n = 0; n < 1700; ) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst; i++, n++) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          send(FN_ALLOC, 16'($urandom), rand_size(), ADDR_W'($urandom));
        end else if (r < 88 && live_blocks.size() > 0) begin
          idx = $urandom_range(0, live_blocks.size() - 1);
          b = live_blocks[idx];
          live_blocks.delete(idx);
          send(FN_FREE, b.owner, REQ_W'($urandom), b.addr);
        end else if (r < 94 && live_blocks.size() > 0) begin
          b = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
          send(FN_FREE, b.owner ^ (16'h1 << $urandom_range(0, 15)), REQ_W'($urandom),
               b.addr);
        end else if (r < 97) begin
          send(FN_ALLOC, 16'($urandom),
               ($urandom_range(0, 1) ? 11'd0 : REQ_W'($urandom_range(1025, 2047))),
               ADDR_W'($urandom));
        end else begin
          send(FN_FREE, 16'($urandom), REQ_W'($urandom), ADDR_W'($urandom));
        end
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 40));
      if ($urandom_range(0, 29) == 0) drain();
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb_buddy_memory_allocator: clean");
    else
      $display("tb_buddy_memory_allocator: errors");
    $finish;
  end

endmodule

/* buddy_memory_allocator.f */
src/bma_pkg.sv
src/bma_ctrl.sv
src/bma_dp.sv
src/buddy_memory_allocator.sv
tb/sv/bma_checker.sv
tb/sv/tb_buddy_memory_allocator.sv
